[sv/text_screen_buffer_edit_assert.svh]
// ---------------------------------------------------------------------------
// text_screen_buffer_edit_assert
// assertion macros used by the screen buffer sequencer tsbe_ctrl
// ---------------------------------------------------------------------------
`ifndef TEXT_SCREEN_BUFFER_EDIT_ASSERT_SVH
`define TEXT_SCREEN_BUFFER_EDIT_ASSERT_SVH

// same-cycle implication
`define TSBE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsbe assertion failed");

// next-cycle implication
`define TSBE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsbe assertion failed");

`endif

[sv/tsbe_pkg.sv]
// ---------------------------------------------------------------------------
// tsbe_pkg
// types and constants of the terminal screen buffer
// ---------------------------------------------------------------------------
package tsbe_pkg;

    localparam logic [1:0] CFG_TOP_ROW     = 2'd0;
    localparam logic [1:0] CFG_BOTTOM_ROW  = 2'd1;
    localparam logic [1:0] CFG_RIGHT_LIMIT = 2'd2;

    localparam logic [5:0] TOP_ROW_RST     = 6'd0;
    localparam logic [6:0] BOTTOM_ROW_RST  = 7'd64;
    localparam logic [7:0] RIGHT_LIMIT_RST = 8'd80;

    localparam logic [7:0] SPACE = 8'h20;

    typedef enum logic [2:0] {
        K_WRITE  = 3'd0,
        K_INS_LN = 3'd1,
        K_DEL_LN = 3'd2,
        K_INS_CH = 3'd3,
        K_DEL_CH = 3'd4,
        K_READ   = 3'd5
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE, S_MAP, S_PLOOK, S_LLOOK, S_SETUP, S_DISP,
        S_FILL, S_WCHR, S_LEN_WR,
        S_REV_INIT, S_REV_CHK, S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
        S_CLR_CHK, S_CL_RA, S_CL_W,
        S_CP_CHK, S_CP_RD, S_CP_WR,
        S_RES_MAP, S_RES_P, S_RES_L, S_RES_C
    } t_state;

    typedef enum logic [1:0] {MA_ROW, MA_LO, MA_HI, MA_RI} t_map_sel;
    typedef enum logic {LW_ZERO, LW_NEW} t_len_wsel;
    typedef enum logic {CR_COL, CR_SRC} t_chr_rsel;
    typedef enum logic [1:0] {CW_BLANK, CW_GLYPH, CW_COPY} t_chr_wsel;
    typedef enum logic [2:0] {
        IOP_HOLD, IOP_FILL_INIT, IOP_COPY_INIT, IOP_UP, IOP_CSTEP
    } t_iop;

    typedef struct packed {
        logic      load;
        t_map_sel  map_sel;
        logic      p_cap;
        logic      len_cap;
        logic      setup;
        logic      tmp_cap;
        logic      map_we_lo;
        logic      map_we_hi;
        logic      rev_init;
        logic      rev_step;
        logic      pass_inc;
        logic      clr_init;
        logic      ri_inc;
        logic      len_we;
        t_len_wsel len_wsel;
        t_chr_rsel chr_rsel;
        logic      chr_we;
        t_chr_wsel chr_wsel;
        t_iop      iop;
        logic      res_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       row_bad;
        logic       col_ok;
        logic       region_ok;
        logic       ich_ok;
        logic       dch_any;
        logic       dch_copy;
        logic       dch_cut;
        logic       fill_more;
        logic       copy_more;
        logic       rev_more;
        logic       pass_last;
        logic       clr_more;
    } t_sts;

endpackage

[sv/tsbe_dp.sv]
// ---------------------------------------------------------------------------
// tsbe_dp
// row map, line lengths, cell store and the pointers that walk them
// ---------------------------------------------------------------------------
module tsbe_dp import tsbe_pkg::*; #(
    parameter int ROWS = 64,
    parameter int COLS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [2:0] i_kind,
    input  logic [5:0] i_row,
    input  logic [6:0] i_col,
    input  logic [7:0] i_col_end,
    input  logic [6:0] i_count,
    input  logic [7:0] i_glyph,
    input  logic [2:0] i_attr,
    input  logic [5:0] i_top_row,
    input  logic [6:0] i_bottom_row,
    input  logic [7:0] i_right_limit,
    output logic [7:0] o_glyph_out,
    output logic [2:0] o_attr_out,
    output logic       o_cell_valid,
    output logic [7:0] o_line_length
);

    localparam int RW  = $clog2(ROWS);
    localparam int CW  = $clog2(COLS);
    localparam int LW  = $clog2(COLS + 1);
    localparam int PW  = ((LW > 8) ? LW : 8) + 1;
    localparam int QW  = ($clog2(ROWS + 1) > 7) ? $clog2(ROWS + 1) : 7;
    localparam int AW  = RW + CW;
    localparam int CD  = ROWS << CW;

    logic [RW-1:0] mem_map [ROWS];
    logic [LW-1:0] mem_len [ROWS];
    logic [10:0]   mem_chr [CD];

    logic [ROWS-1:0] r_map_vld;
    logic [ROWS-1:0] r_len_vld;

    logic [2:0]    r_kind;
    logic [5:0]    r_row;
    logic [6:0]    r_col;
    logic [7:0]    r_cend;
    logic [6:0]    r_cnt;
    logic [7:0]    r_glyph;
    logic [2:0]    r_attr;

    logic [RW-1:0] r_map_q, r_map_a;
    logic          r_map_v;
    logic [LW-1:0] r_len_q;
    logic          r_len_v;
    logic [10:0]   r_chr_q;

    logic [RW-1:0] r_p, r_tmp;
    logic [LW-1:0] r_len;
    logic [QW-1:0] r_lo, r_hi, r_ri, r_k, r_cs, r_ce, r_bot;
    logic [1:0]    r_pass;
    logic [PW-1:0] r_i, r_dlt, r_to, r_newlen, r_fend;

    logic [RW-1:0] map_eff, map_ra, map_wa, map_wd;
    logic          map_we;
    logic [LW-1:0] len_eff, len_wd;
    logic [RW-1:0] len_wa;
    logic [AW-1:0] chr_ra, chr_wa;
    logic [10:0]   chr_wd;

    logic [QW-1:0] row_q, bot, m, n, k, hm1;
    logic [PW-1:0] colp, cendp, lenp, rightp, dlt, sum, to, nl_ins, newlen, src, dst;
    logic          row_bad, res_valid;

    assign row_q  = QW'(r_row);
    assign colp   = PW'(r_col);
    assign cendp  = PW'(r_cend);
    assign lenp   = PW'(r_len);
    assign bot    = (QW'(i_bottom_row) < QW'(ROWS)) ? QW'(i_bottom_row) : QW'(ROWS);
    assign rightp = (PW'(i_right_limit) < PW'(COLS)) ? PW'(i_right_limit) : PW'(COLS);
    assign hm1    = r_hi - QW'(1);
    assign row_bad = row_q >= QW'(ROWS);

    // line operation setup
    assign m = bot - row_q;
    assign n = (QW'(r_cnt) > m) ? m : QW'(r_cnt);
    assign k = (r_kind == K_INS_LN) ? (m - n) : n;

    // char operation setup
    assign dlt    = cendp - colp;
    assign sum    = lenp + dlt;
    assign nl_ins = (sum > rightp) ? rightp : sum;
    assign to     = (cendp > rightp) ? rightp : cendp;

    always_comb begin
        unique case (r_kind)
            K_WRITE:  newlen = (lenp < colp + PW'(1)) ? colp + PW'(1) : lenp;
            K_INS_CH: newlen = nl_ins;
            K_DEL_CH: newlen = (cendp < lenp) ? lenp - dlt : colp;
            default:  newlen = lenp;
        endcase
    end

    assign src = (r_kind == K_INS_CH) ? r_i - PW'(1) - r_dlt : r_i;
    assign dst = (r_kind == K_INS_CH) ? r_i - PW'(1) : r_i - r_dlt;

    // row map
    assign map_eff = r_map_v ? r_map_q : r_map_a;

    always_comb begin
        unique case (i_cmd.map_sel)
            MA_ROW: map_ra = RW'(row_q);
            MA_LO:  map_ra = RW'(r_lo);
            MA_HI:  map_ra = RW'(hm1);
            MA_RI:  map_ra = RW'(r_ri);
        endcase
    end

    assign map_we = i_cmd.map_we_lo | i_cmd.map_we_hi;
    assign map_wa = i_cmd.map_we_lo ? RW'(r_lo) : RW'(hm1);
    assign map_wd = i_cmd.map_we_lo ? map_eff : r_tmp;

    always_ff @(posedge i_clk) begin
        r_map_q <= mem_map[map_ra];
        r_map_a <= map_ra;
        r_map_v <= r_map_vld[map_ra];
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
        end else if (map_we) begin
            r_map_vld[map_wa] <= 1'b1;
        end
    end

    // line lengths
    assign len_eff = r_len_v ? r_len_q : '0;
    assign len_wa  = (i_cmd.len_wsel == LW_ZERO) ? map_eff : r_p;
    assign len_wd  = (i_cmd.len_wsel == LW_ZERO) ? '0 : LW'(r_newlen);

    always_ff @(posedge i_clk) begin
        r_len_q <= mem_len[map_eff];
        r_len_v <= r_len_vld[map_eff];
        if (i_cmd.len_we) begin
            mem_len[len_wa] <= len_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
        end else if (i_cmd.len_we) begin
            r_len_vld[len_wa] <= 1'b1;
        end
    end

    // cell store
    assign chr_ra = (i_cmd.chr_rsel == CR_SRC) ? {r_p, CW'(src)} : {r_p, CW'(r_col)};

    always_comb begin
        unique case (i_cmd.chr_wsel)
            CW_BLANK: begin
                chr_wa = {r_p, CW'(r_i)};
                chr_wd = {SPACE, 3'b000};
            end
            CW_GLYPH: begin
                chr_wa = {r_p, CW'(r_col)};
                chr_wd = {r_glyph, r_attr};
            end
            CW_COPY: begin
                chr_wa = {r_p, CW'(dst)};
                chr_wd = r_chr_q;
            end
            default: begin
                chr_wa = {r_p, CW'(r_i)};
                chr_wd = r_chr_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_chr_q <= mem_chr[chr_ra];
        if (i_cmd.chr_we) begin
            mem_chr[chr_wa] <= chr_wd;
        end
    end

    // command word and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_row   <= i_row;
            r_col   <= i_col;
            r_cend  <= i_col_end;
            r_cnt   <= i_count;
            r_glyph <= i_glyph;
            r_attr  <= i_attr;
        end
        if (i_cmd.p_cap) begin
            r_p <= map_eff;
        end
        if (i_cmd.len_cap) begin
            r_len <= len_eff;
        end
        if (i_cmd.tmp_cap) begin
            r_tmp <= map_eff;
        end
        if (i_cmd.setup) begin
            r_bot    <= bot;
            r_k      <= k;
            r_cs     <= (r_kind == K_INS_LN) ? row_q : bot - n;
            r_ce     <= (r_kind == K_INS_LN) ? row_q + n : bot;
            r_dlt    <= dlt;
            r_to     <= to;
            r_newlen <= newlen;
            r_fend   <= (r_kind == K_WRITE) ? colp : to;
            r_pass   <= 2'd0;
        end
        if (i_cmd.rev_init) begin
            unique case (r_pass)
                2'd0: begin
                    r_lo <= row_q;
                    r_hi <= row_q + r_k;
                end
                2'd1: begin
                    r_lo <= row_q + r_k;
                    r_hi <= r_bot;
                end
                default: begin
                    r_lo <= row_q;
                    r_hi <= r_bot;
                end
            endcase
        end else if (i_cmd.rev_step) begin
            r_lo <= r_lo + QW'(1);
            r_hi <= r_hi - QW'(1);
        end
        if (i_cmd.pass_inc) begin
            r_pass <= r_pass + 2'd1;
        end
        if (i_cmd.clr_init) begin
            r_ri <= r_cs;
        end else if (i_cmd.ri_inc) begin
            r_ri <= r_ri + QW'(1);
        end
        unique case (i_cmd.iop)
            IOP_HOLD:      r_i <= r_i;
            IOP_FILL_INIT: r_i <= (r_kind == K_WRITE) ? lenp : colp;
            IOP_COPY_INIT: r_i <= (r_kind == K_INS_CH) ? r_newlen : cendp;
            IOP_UP:        r_i <= r_i + PW'(1);
            IOP_CSTEP:     r_i <= (r_kind == K_INS_CH) ? r_i - PW'(1) : r_i + PW'(1);
            default:       r_i <= r_i;
        endcase
    end

    // result word
    assign res_valid = !row_bad && (colp < lenp) && (colp < PW'(COLS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_cell_valid  <= res_valid;
            o_glyph_out   <= res_valid ? r_chr_q[10:3] : 8'd0;
            o_attr_out    <= res_valid ? r_chr_q[2:0] : 3'd0;
            o_line_length <= row_bad ? 8'd0 : lenp[7:0];
        end
    end

    // status
    assign o_sts.kind      = r_kind;
    assign o_sts.row_bad   = row_bad;
    assign o_sts.col_ok    = colp < PW'(COLS);
    assign o_sts.region_ok = (row_q >= QW'(i_top_row)) && (row_q < bot);
    assign o_sts.ich_ok    = (colp < cendp) && (colp < lenp);
    assign o_sts.dch_any   = colp < cendp;
    assign o_sts.dch_copy  = cendp < lenp;
    assign o_sts.dch_cut   = colp < lenp;
    assign o_sts.fill_more = r_i < r_fend;
    assign o_sts.copy_more = (r_kind == K_INS_CH) ? (r_i > r_to) : (r_i < lenp);
    assign o_sts.rev_more  = r_hi > r_lo + QW'(1);
    assign o_sts.pass_last = r_pass == 2'd2;
    assign o_sts.clr_more  = r_ri < r_ce;

endmodule

[sv/tsbe_ctrl.sv]
// ---------------------------------------------------------------------------
// tsbe_ctrl
// command sequencer of the terminal screen buffer
// ---------------------------------------------------------------------------
`include "text_screen_buffer_edit_assert.svh"

module tsbe_ctrl import tsbe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_valid
);

    t_state r_state, n_state;
    logic   r_done;
    t_cmd   cmd;
    t_sts   sts;
    logic   line_op;

    assign sts = i_sts;
    assign line_op = (sts.kind == K_INS_LN) || (sts.kind == K_DEL_LN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= cmd.res_load;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    n_state = i_start ? S_MAP : S_IDLE;
            S_MAP:     n_state = S_PLOOK;
            S_PLOOK:   n_state = S_LLOOK;
            S_LLOOK:   n_state = S_SETUP;
            S_SETUP:   n_state = S_DISP;
            S_DISP: begin
                if (sts.row_bad) begin
                    n_state = S_RES_C;
                end else begin
                    unique case (sts.kind)
                        K_WRITE:  n_state = sts.col_ok ? S_FILL : S_RES_MAP;
                        K_INS_LN: n_state = sts.region_ok ? S_REV_INIT : S_RES_MAP;
                        K_DEL_LN: n_state = sts.region_ok ? S_REV_INIT : S_RES_MAP;
                        K_INS_CH: n_state = sts.ich_ok ? S_CP_CHK : S_RES_MAP;
                        K_DEL_CH: begin
                            priority if (sts.dch_any && sts.dch_copy) begin
                                n_state = S_CP_CHK;
                            end else if (sts.dch_any && sts.dch_cut) begin
                                n_state = S_LEN_WR;
                            end else begin
                                n_state = S_RES_MAP;
                            end
                        end
                        default:  n_state = S_RES_MAP;
                    endcase
                end
            end
            S_FILL: begin
                priority if (sts.fill_more) begin
                    n_state = S_FILL;
                end else if (sts.kind == K_WRITE) begin
                    n_state = S_WCHR;
                end else begin
                    n_state = S_LEN_WR;
                end
            end
            S_WCHR:    n_state = S_LEN_WR;
            S_LEN_WR:  n_state = S_RES_MAP;
            S_REV_INIT: n_state = S_REV_CHK;
            S_REV_CHK: begin
                priority if (sts.rev_more) begin
                    n_state = S_SW_RA;
                end else if (sts.pass_last) begin
                    n_state = S_CLR_CHK;
                end else begin
                    n_state = S_REV_INIT;
                end
            end
            S_SW_RA:   n_state = S_SW_RB;
            S_SW_RB:   n_state = S_SW_WA;
            S_SW_WA:   n_state = S_SW_WB;
            S_SW_WB:   n_state = S_REV_CHK;
            S_CLR_CHK: n_state = sts.clr_more ? S_CL_RA : S_RES_MAP;
            S_CL_RA:   n_state = S_CL_W;
            S_CL_W:    n_state = S_CLR_CHK;
            S_CP_CHK: begin
                priority if (sts.copy_more) begin
                    n_state = S_CP_RD;
                end else if (sts.kind == K_INS_CH) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_LEN_WR;
                end
            end
            S_CP_RD:   n_state = S_CP_WR;
            S_CP_WR:   n_state = S_CP_CHK;
            S_RES_MAP: n_state = S_RES_P;
            S_RES_P:   n_state = S_RES_L;
            S_RES_L:   n_state = S_RES_C;
            S_RES_C:   n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (r_state)
            S_IDLE:   cmd.load = i_start;
            S_MAP:    cmd.map_sel = MA_ROW;
            S_PLOOK:  cmd.p_cap = 1'b1;
            S_LLOOK:  cmd.len_cap = 1'b1;
            S_SETUP:  cmd.setup = 1'b1;
            S_DISP: begin
                if (!sts.row_bad && sts.kind == K_WRITE && sts.col_ok) begin
                    cmd.iop = IOP_FILL_INIT;
                end else if (!sts.row_bad && sts.kind == K_INS_CH && sts.ich_ok) begin
                    cmd.iop = IOP_COPY_INIT;
                end else if (!sts.row_bad && sts.kind == K_DEL_CH && sts.dch_any
                             && sts.dch_copy) begin
                    cmd.iop = IOP_COPY_INIT;
                end
            end
            S_FILL: begin
                if (sts.fill_more) begin
                    cmd.chr_we   = 1'b1;
                    cmd.chr_wsel = CW_BLANK;
                    cmd.iop      = IOP_UP;
                end
            end
            S_WCHR: begin
                cmd.chr_we   = 1'b1;
                cmd.chr_wsel = CW_GLYPH;
            end
            S_LEN_WR: begin
                cmd.len_we   = 1'b1;
                cmd.len_wsel = LW_NEW;
            end
            S_REV_INIT: cmd.rev_init = 1'b1;
            S_REV_CHK: begin
                if (!sts.rev_more && sts.pass_last) begin
                    cmd.clr_init = 1'b1;
                end else if (!sts.rev_more) begin
                    cmd.pass_inc = 1'b1;
                end
            end
            S_SW_RA:  cmd.map_sel = MA_LO;
            S_SW_RB: begin
                cmd.map_sel = MA_HI;
                cmd.tmp_cap = 1'b1;
            end
            S_SW_WA:  cmd.map_we_lo = 1'b1;
            S_SW_WB: begin
                cmd.map_we_hi = 1'b1;
                cmd.rev_step  = 1'b1;
            end
            S_CLR_CHK: cmd.map_sel = MA_RI;
            S_CL_RA:  cmd.map_sel = MA_RI;
            S_CL_W: begin
                cmd.len_we   = 1'b1;
                cmd.len_wsel = LW_ZERO;
                cmd.ri_inc   = 1'b1;
            end
            S_CP_CHK: begin
                if (!sts.copy_more && sts.kind == K_INS_CH) begin
                    cmd.iop = IOP_FILL_INIT;
                end
            end
            S_CP_RD:  cmd.chr_rsel = CR_SRC;
            S_CP_WR: begin
                cmd.chr_we   = 1'b1;
                cmd.chr_wsel = CW_COPY;
                cmd.iop      = IOP_CSTEP;
            end
            S_RES_MAP: cmd.map_sel = MA_ROW;
            S_RES_P:  cmd.p_cap = 1'b1;
            S_RES_L: begin
                cmd.len_cap  = 1'b1;
                cmd.chr_rsel = CR_COL;
            end
            S_RES_C:  cmd.res_load = 1'b1;
            default:  cmd = '0;
        endcase
    end

    assign o_cmd   = cmd;
    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_done;

    `TSBE_ASSERT_NXT(a_start_taken, i_start && (r_state == S_IDLE), r_state == S_MAP)
    `TSBE_ASSERT_NXT(a_done_idle, cmd.res_load, (r_state == S_IDLE) && r_done)
    `TSBE_ASSERT_IMP(a_done_single, r_done, !$past(r_done))
    `TSBE_ASSERT_IMP(a_map_wr_lines, cmd.map_we_lo || cmd.map_we_hi, sts.region_ok && line_op)

endmodule

[sv/text_screen_buffer_edit.sv]
// ---------------------------------------------------------------------------
// text_screen_buffer_edit
// character-cell screen store with row map, line and char editing
// ---------------------------------------------------------------------------
// latency start to o_valid depends on the command: a write blanks up to its column, then
// writes glyph and length; insert chars shifts cells right, then blanks; delete chars moves
// cells left (a plain cut only sets the length); line ops swap row-map entries over three
// reversals, then clear rows; one command at a time, start taken again while o_valid shows
// o_valid is a one-cycle strobe that nothing holds off; synchronous active-low reset
// row map reads as identity and lengths as zero after reset through per-entry valid bits
module text_screen_buffer_edit import tsbe_pkg::*; #(
    parameter int ROWS = 64,
    parameter int COLS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_kind,
    input  logic [5:0] i_row,
    input  logic [6:0] i_col,
    input  logic [7:0] i_col_end,
    input  logic [6:0] i_count,
    input  logic [7:0] i_glyph,
    input  logic [2:0] i_attr,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    output logic [7:0] o_glyph_out,
    output logic [2:0] o_attr_out,
    output logic       o_cell_valid,
    output logic [7:0] o_line_length
);

    logic [5:0] r_top_row;
    logic [6:0] r_bottom_row;
    logic [7:0] r_right_limit;
    t_cmd       cmd;
    t_sts       sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_row     <= TOP_ROW_RST;
            r_bottom_row  <= BOTTOM_ROW_RST;
            r_right_limit <= RIGHT_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOP_ROW:     r_top_row     <= i_cfg_data[5:0];
                CFG_BOTTOM_ROW:  r_bottom_row  <= i_cfg_data[6:0];
                CFG_RIGHT_LIMIT: r_right_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tsbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    tsbe_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_col_end     (i_col_end),
        .i_count       (i_count),
        .i_glyph       (i_glyph),
        .i_attr        (i_attr),
        .i_top_row     (r_top_row),
        .i_bottom_row  (r_bottom_row),
        .i_right_limit (r_right_limit),
        .o_glyph_out   (o_glyph_out),
        .o_attr_out    (o_attr_out),
        .o_cell_valid  (o_cell_valid),
        .o_line_length (o_line_length)
    );

endmodule
